// ===== design/kf2_pkg.sv =====
// Shared types and constants for the two-state Kalman filter core.
// No dependencies.
package kf2_pkg;

  localparam int unsigned RegIdxW  = 3;
  localparam logic signed [31:0] QMax = 32'sh7fffffff;
  localparam logic signed [31:0] QMin = 32'sh80000000;

  localparam logic [RegIdxW-1:0] RegTrans00 = 3'd0;
  localparam logic [RegIdxW-1:0] RegTrans01 = 3'd1;
  localparam logic [RegIdxW-1:0] RegTrans10 = 3'd2;
  localparam logic [RegIdxW-1:0] RegTrans11 = 3'd3;
  localparam logic [RegIdxW-1:0] RegMeasNoise = 3'd4;
  localparam logic [RegIdxW-1:0] RegProcPos = 3'd5;
  localparam logic [RegIdxW-1:0] RegProcVel = 3'd6;
  localparam logic [RegIdxW-1:0] RegInitVar = 3'd7;

  // shared unit operations
  typedef enum logic [1:0] {
    OpMul = 2'd0,
    OpAdd = 2'd1,
    OpSub = 2'd2
  } alu_op_e;

  // saturate a 34-bit exact sum to Q16.16
  function automatic logic [32:0] clip_sum(input logic signed [33:0] v);
    logic [32:0] r;
    if (v > 34'sh07fffffff)       r = {1'b1, QMax};
    else if (v < -34'sh080000000) r = {1'b1, QMin};
    else                          r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// ===== design/kf2_div.sv =====
// Restoring divider for the Kalman gain: (num * 2^16) / den, truncated, clipped.
// Depends on kf2_pkg. One quotient bit per cycle.
module kf2_div import kf2_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o,
  output logic               clip_o
);
  logic [47:0] rem_q, rem_d, quo_q, quo_d, dvd_q, dvd_d;
  logic [30:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [48:0] trial;
  logic [47:0] shifted;
  logic [31:0] absnum;

  assign absnum  = num_i[31] ? 32'(-num_i) : num_i;
  assign shifted = {rem_q[46:0], dvd_q[47]};
  assign trial   = {1'b0, shifted} - {18'd0, den_q};

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; dvd_d = dvd_q; den_d = den_q;
    neg_d = neg_q; cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      rem_d = '0; quo_d = '0;
      dvd_d = {absnum, 16'd0};
      den_d = den_i[30:0];
      neg_d = num_i[31];
      cnt_d = 6'd47;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[46:0], 1'b0};
      if (!trial[48]) begin
        rem_d = trial[47:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_o <= busy_q && (cnt_q == 6'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvd_q <= dvd_d; den_q <= den_d; neg_q <= neg_d;
  end

  // magnitude is clipped at 2^31-1 (positive) or 2^31 (negative)
  always_comb begin
    clip_o = 1'b0;
    if (!neg_q) begin
      if (quo_q > 48'h7fffffff) begin clip_o = 1'b1; quot_o = QMax; end
      else quot_o = quo_q[31:0];
    end else begin
      if (quo_q > 48'h80000000) begin clip_o = 1'b1; quot_o = QMin; end
      else quot_o = 32'(-quo_q[31:0]);
    end
  end

endmodule

// ===== design/kalman_filter_two_state_core.sv =====
// Top level of the two-state Kalman filter: registers, sequencer, shared ALU.
// Depends on kf2_pkg and kf2_div.
//
//  channel | signals                               | direction
//  cfg     | cfg_valid/ready, cfg_index, cfg_data   | in
//  req     | req_valid/ready, req_type, meas/ctrl   | in
//  res     | res_valid/ready, out_*, flags          | out
//
// A restart request goes straight from idle to output. A filter step runs a
// 35-step prediction microprogram through one shared multiply/add unit (20 multiplies,
// product registered then clipped, and 15 adds), two gain divisions of 48 quotient
// bits each and a 14-step update, then commit and output; the divisions and update
// are skipped when S is not positive. The result register holds until taken; the
// next request is taken meanwhile, and the sequencer stalls at output until the
// register is free.
// Reset loads the documented defaults.
module kalman_filter_two_state_core import kf2_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic               req_type_i,
  input  logic signed [31:0] meas_pos_i,
  input  logic signed [31:0] ctrl_pos_i,
  input  logic signed [31:0] ctrl_vel_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic signed [31:0] out_pos_o,
  output logic signed [31:0] out_vel_o,
  output logic signed [31:0] out_p00_o,
  output logic signed [31:0] out_p01_o,
  output logic signed [31:0] out_p10_o,
  output logic signed [31:0] out_p11_o,
  output logic               saturated_o,
  output logic               update_skipped_o
);
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StAlu   = 6'b000010,
    StDiv0  = 6'b000100,
    StDiv1  = 6'b001000,
    StOut   = 6'b010000,
    StWait  = 6'b100000
  } state_e;

  // scratch register file: operands and intermediates
  localparam int unsigned NRf = 24;
  localparam logic [4:0] RX0 = 5'd0, RX1 = 5'd1, RP0 = 5'd2, RP1 = 5'd3, RP2 = 5'd4,
    RP3 = 5'd5, RF0 = 5'd6, RF1 = 5'd7, RF2 = 5'd8, RF3 = 5'd9, RR = 5'd10, RQ0 = 5'd11,
    RQ1 = 5'd12, RZ = 5'd13, RU0 = 5'd14, RU1 = 5'd15, RT = 5'd16, RA0 = 5'd17,
    RA1 = 5'd18, RA2 = 5'd19, RA3 = 5'd20, RXP0 = 5'd21, RXP1 = 5'd22, RK0 = 5'd23;

  typedef struct packed {
    alu_op_e    op;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] d;
  } uop_t;

  localparam int unsigned NProg = 35;

  function automatic uop_t prog(input logic [5:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = '{OpMul, RF0, RX0, RT};
      6'd1:  u = '{OpMul, RF1, RX1, RXP0};
      6'd2:  u = '{OpAdd, RT, RXP0, RXP0};
      6'd3:  u = '{OpAdd, RXP0, RU0, RXP0};
      6'd4:  u = '{OpMul, RF2, RX0, RT};
      6'd5:  u = '{OpMul, RF3, RX1, RXP1};
      6'd6:  u = '{OpAdd, RT, RXP1, RXP1};
      6'd7:  u = '{OpAdd, RXP1, RU1, RXP1};
      6'd8:  u = '{OpMul, RF0, RP0, RT};
      6'd9:  u = '{OpMul, RF1, RP2, RA0};
      6'd10: u = '{OpAdd, RT, RA0, RA0};
      6'd11: u = '{OpMul, RF0, RP1, RT};
      6'd12: u = '{OpMul, RF1, RP3, RA1};
      6'd13: u = '{OpAdd, RT, RA1, RA1};
      6'd14: u = '{OpMul, RF2, RP0, RT};
      6'd15: u = '{OpMul, RF3, RP2, RA2};
      6'd16: u = '{OpAdd, RT, RA2, RA2};
      6'd17: u = '{OpMul, RF2, RP1, RT};
      6'd18: u = '{OpMul, RF3, RP3, RA3};
      6'd19: u = '{OpAdd, RT, RA3, RA3};
      // Ppred = A * F^T, written over P
      6'd20: u = '{OpMul, RA0, RF0, RT};
      6'd21: u = '{OpMul, RA1, RF1, RP0};
      6'd22: u = '{OpAdd, RT, RP0, RP0};
      6'd23: u = '{OpMul, RA0, RF2, RT};
      6'd24: u = '{OpMul, RA1, RF3, RP1};
      6'd25: u = '{OpAdd, RT, RP1, RP1};
      6'd26: u = '{OpMul, RA2, RF0, RT};
      6'd27: u = '{OpMul, RA3, RF1, RP2};
      6'd28: u = '{OpAdd, RT, RP2, RP2};
      6'd29: u = '{OpMul, RA2, RF2, RT};
      6'd30: u = '{OpMul, RA3, RF3, RP3};
      6'd31: u = '{OpAdd, RT, RP3, RP3};
      6'd32: u = '{OpAdd, RP0, RQ0, RP0};
      6'd33: u = '{OpAdd, RP3, RQ1, RP3};
      6'd34: u = '{OpAdd, RP0, RR, RT};   // S
      default: u = '{OpAdd, RT, RT, RT};
    endcase
    return u;
  endfunction

  // update phase: RA0=K0, RA1=K1, RA2=y after divisions
  function automatic uop_t upd(input logic [4:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{OpSub, RZ, RXP0, RA2};
      5'd1:  u = '{OpMul, RA0, RA2, RT};
      5'd2:  u = '{OpAdd, RXP0, RT, RX0};
      5'd3:  u = '{OpMul, RA1, RA2, RT};
      5'd4:  u = '{OpAdd, RXP1, RT, RX1};
      5'd5:  u = '{OpMul, RA0, RP0, RT};
      5'd6:  u = '{OpMul, RA0, RP1, RA3};
      5'd7:  u = '{OpSub, RP1, RA3, RA3};
      5'd8:  u = '{OpMul, RA1, RP0, RK0};
      5'd9:  u = '{OpSub, RP2, RK0, RP2};
      5'd10: u = '{OpMul, RA1, RP1, RK0};
      5'd11: u = '{OpSub, RP3, RK0, RP3};
      5'd12: u = '{OpSub, RP0, RT, RP0};
      5'd13: u = '{OpAdd, RA3, RQ1, RP1}; // RQ1 zeroed when the second division completes
      default: u = '{OpAdd, RT, RT, RT};
    endcase
    return u;
  endfunction

  state_e      state_q, state_d;
  logic [31:0] rf_q [NRf];
  logic [31:0] trans00_q, trans01_q, trans10_q, trans11_q;
  logic [30:0] meas_noise_q, proc_pos_q, proc_vel_q, init_var_q;
  logic [31:0] est_q [4];
  logic [31:0] pos_q, vel_q;
  logic [5:0]  pc_q;
  logic        upd_q, mpend_q, sat_q, skip_q;
  logic signed [63:0] prod_q;
  logic        div_start, div_done, div_clip;
  logic signed [31:0] div_quot;
  logic [31:0] div_num;
  logic [31:0] div_den;
  uop_t        u;
  logic signed [31:0] opa, opb;
  logic [32:0] add_res;
  logic [32:0] mul_res;
  logic signed [63:0] prod_rnd;
  logic signed [47:0] floored;
  logic        last_op;
  logic        out_go;

  assign cfg_ready_o = (state_q == StIdle);
  assign req_ready_o = (state_q == StIdle);

  assign u   = upd_q ? upd(pc_q[4:0]) : prog(pc_q);
  assign opa = rf_q[u.a];
  assign opb = rf_q[u.b];
  always_comb begin
    if (u.op == OpSub) add_res = clip_sum(34'(opa) - 34'(opb));
    else               add_res = clip_sum(34'(opa) + 34'(opb));
  end
  // round half up, floor shift, clip
  assign prod_rnd = prod_q + 64'sd32768;
  assign floored  = prod_rnd[63:16];
  always_comb begin
    if (floored > 48'sh7fffffff)       mul_res = {1'b1, QMax};
    else if (floored < -48'sh80000000) mul_res = {1'b1, QMin};
    else                               mul_res = {1'b0, floored[31:0]};
  end

  assign last_op = upd_q ? (pc_q == 6'd13) : (pc_q == 6'(NProg - 1));
  assign out_go  = (state_q == StOut) && (!res_valid_o || res_ready_i);

  // first gain starts straight from S as it leaves the adder
  assign div_start = (state_q == StAlu) && !upd_q && last_op
                     && ($signed(add_res[31:0]) > 0)
                   || (state_q == StDiv0) && div_done;
  assign div_num   = (state_q == StDiv0) ? rf_q[RP2] : rf_q[RP0];
  assign div_den   = (state_q == StAlu) ? add_res[31:0] : rf_q[RT];

  kf2_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot),
    .clip_o (div_clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      trans00_q <= 32'h10000; trans01_q <= 32'h10000;
      trans10_q <= '0; trans11_q <= 32'h10000;
      meas_noise_q <= 31'h10000; proc_pos_q <= '0; proc_vel_q <= '0;
      init_var_q <= 31'd65536000;
      pos_q <= '0; vel_q <= '0;
      est_q[0] <= 32'd65536000; est_q[1] <= '0; est_q[2] <= '0;
      est_q[3] <= 32'd65536000;
      res_valid_o <= 1'b0;
      pc_q <= '0; upd_q <= 1'b0; mpend_q <= 1'b0; sat_q <= 1'b0; skip_q <= 1'b0;
    end else begin
      if (out_go) res_valid_o <= 1'b1;
      else if (res_valid_o && res_ready_i) res_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegTrans00:   trans00_q <= cfg_data_i;
          RegTrans01:   trans01_q <= cfg_data_i;
          RegTrans10:   trans10_q <= cfg_data_i;
          RegTrans11:   trans11_q <= cfg_data_i;
          RegMeasNoise: meas_noise_q <= cfg_data_i[30:0];
          RegProcPos:   proc_pos_q <= cfg_data_i[30:0];
          RegProcVel:   proc_vel_q <= cfg_data_i[30:0];
          RegInitVar:   init_var_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: if (req_valid_i && req_ready_o) begin
          sat_q <= 1'b0; skip_q <= 1'b0; pc_q <= '0; upd_q <= 1'b0; mpend_q <= 1'b0;
          if (req_type_i) begin
            pos_q <= '0; vel_q <= '0;
            est_q[0] <= {1'b0, init_var_q}; est_q[1] <= '0; est_q[2] <= '0;
            est_q[3] <= {1'b0, init_var_q};
            state_q <= StOut;
          end else begin
            state_q <= StAlu;
          end
        end
        StAlu: begin
          // multiply: the product is registered first, then clipped and written
          if (u.op == OpMul && !mpend_q) begin
            mpend_q <= 1'b1;
          end else begin
            mpend_q <= 1'b0;
            if (u.op == OpMul) sat_q <= sat_q | mul_res[32];
            else               sat_q <= sat_q | add_res[32];
            if (last_op) begin
              if (upd_q) state_q <= StWait;
              else if ($signed(add_res[31:0]) > 0) state_q <= StDiv0;
              else begin skip_q <= 1'b1; state_q <= StWait; end
            end else begin
              pc_q <= pc_q + 6'd1;
            end
          end
        end
        StDiv0: if (div_done) begin
          sat_q <= sat_q | div_clip; state_q <= StDiv1;
        end
        StDiv1: if (div_done) begin
          sat_q <= sat_q | div_clip; state_q <= StAlu; upd_q <= 1'b1; pc_q <= '0;
        end
        StWait: begin
          // commit working copy to the estimate
          pos_q <= rf_q[upd_q ? RX0 : RXP0];
          vel_q <= rf_q[upd_q ? RX1 : RXP1];
          est_q[0] <= rf_q[RP0]; est_q[1] <= rf_q[RP1];
          est_q[2] <= rf_q[RP2]; est_q[3] <= rf_q[RP3];
          state_q <= StOut;
        end
        StOut: begin
          // hold until the result register is free
          if (out_go) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(opa) * 64'(opb);
    if (state_q == StIdle && req_valid_i && req_ready_o) begin
      rf_q[RX0] <= pos_q; rf_q[RX1] <= vel_q;
      rf_q[RP0] <= est_q[0]; rf_q[RP1] <= est_q[1];
      rf_q[RP2] <= est_q[2]; rf_q[RP3] <= est_q[3];
      rf_q[RF0] <= trans00_q; rf_q[RF1] <= trans01_q;
      rf_q[RF2] <= trans10_q; rf_q[RF3] <= trans11_q;
      rf_q[RR] <= {1'b0, meas_noise_q};
      rf_q[RQ0] <= {1'b0, proc_pos_q}; rf_q[RQ1] <= {1'b0, proc_vel_q};
      rf_q[RZ] <= meas_pos_i; rf_q[RU0] <= ctrl_pos_i; rf_q[RU1] <= ctrl_vel_i;
    end else if (state_q == StAlu && !(u.op == OpMul && !mpend_q)) begin
      rf_q[u.d] <= (u.op == OpMul) ? mul_res[31:0] : add_res[31:0];
    end else if (div_done) begin
      if (state_q == StDiv0) rf_q[RA0] <= div_quot;
      else begin rf_q[RA1] <= div_quot; rf_q[RQ1] <= '0; end
    end
  end

  // output register follows the committed estimate
  always_ff @(posedge clk_i) begin
    if (out_go) begin
      out_pos_o <= pos_q; out_vel_o <= vel_q;
      out_p00_o <= est_q[0]; out_p01_o <= est_q[1];
      out_p10_o <= est_q[2]; out_p11_o <= est_q[3];
      saturated_o <= sat_q; update_skipped_o <= skip_q;
    end
  end

  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !req_ready_o) else $error("request taken while busy");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> res_valid_o) else $error("result dropped");
  a_skip_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_q && state_q == StWait) |-> !upd_q) else $error("skip after update");
  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");

endmodule
